@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file; clk and rst_n come from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, off while reset is held.
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define TCW_ASSERT_NXT_NR(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

@@ hdl/tcw_pkg.sv @@
// Shared constants, field layout and op codes of the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CUR_FW = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);

  // input word layout
  localparam int IN_CHAR_LSB = 0;
  localparam int IN_ATTR_LSB = IN_CHAR_LSB + CHAR_W;
  localparam int IN_IDX_LSB  = IN_ATTR_LSB + ATTR_W;
  localparam int IN_USED_W   = IN_IDX_LSB + IDX_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // output word layout
  localparam int OUT_CUR_LSB  = 0;
  localparam int OUT_CHAR_LSB = OUT_CUR_LSB + CUR_FW;
  localparam int OUT_ATTR_LSB = OUT_CHAR_LSB + CHAR_W;
  localparam int OUT_SCR_BIT  = OUT_ATTR_LSB + ATTR_W;
  localparam int OUT_USED_W   = OUT_SCR_BIT + 1;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] NUL_CHAR     = CHAR_W'(0);
  localparam logic [ATTR_W-1:0] DEF_ATTR_RST = ATTR_W'(15);

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

endpackage

@@ hdl/text_console_writer_core.sv @@
// Text console writer: cell memory, cursor tracking, scroll and clear sweeps.
//
// A ROWS x COLUMNS grid of 16-bit cells (character in the low byte,
// attribute in the high byte) sits in one single-port-write, one-read
// synchronous RAM. The input word carries the op in in_tuser: put a
// character (newline moves to the next row), read a cell, or clear the
// screen. Every accepted word gives exactly one output word with the cursor
// after the op, the read cell (zero unless a valid read), and a scrolled
// flag. Put character, newline without scroll, a read outside the grid
// and the unused op finish in the execute step; a read inside the grid
// adds a read-data step for the registered RAM read. A scroll or a clear
// walks the whole RAM one cell per cycle; a scroll copies each row up
// from the row below (read one cycle, write back the next) and fills the
// last row, a clear fills every cell. A stalled result register holds the
// op in its execute step until out_tready frees it. After reset the RAM is
// cleared to zero by the same sweep; in_tready stays low while it runs.
// cfg_we/cfg_wdata set the default attribute for cleared and scrolled-in
// cells and are taken at any time. The result sits in an output register, so
// the next word is accepted while the previous result waits.
module text_console_writer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: character [7:0], attribute [15:8], cell_index [26:16], zero pad
  input  logic [tcw_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op [1:0]
  input  logic [tcw_pkg::OP_W-1:0]       in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: cursor_cell [10:0], cell_char [18:11], cell_attr [26:19],
  //            scrolled [27], zero pad
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_wdata
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,   // reset clearing sweep
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_SWEEP   // scroll or clear sweep, then finish
  } state_t;

  localparam logic [CUR_W-1:0] CELLS_C   = CUR_W'(CELLS);
  localparam logic [CUR_W-1:0] COLS_C    = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0] LAST_ROW  = CUR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

  // cell memory
  logic [CELL_W-1:0] cell_mem_r [CELLS];
  logic [CELL_W-1:0] mem_q_r;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  // control and cursor state
  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    cmd_op_r, cmd_op_nxt;
  logic [CHAR_W-1:0]  cmd_char_r, cmd_char_nxt;
  logic [ATTR_W-1:0]  cmd_attr_r, cmd_attr_nxt;
  logic [IDX_W-1:0]   cmd_idx_r, cmd_idx_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [CUR_W-1:0]   base_r, base_nxt;     // first cell of the cursor row
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ATTR_W-1:0]  dattr_r, dattr_nxt;
  logic [CUR_W-1:0]   sw_r, sw_nxt;         // sweep position
  logic               copy_r, copy_nxt;     // sweep copies rows up (scroll)
  logic               scr_r, scr_nxt;
  logic               put_after_r, put_after_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic               pend_copy_r, pend_copy_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;

  // result register
  logic               out_v_r, out_v_nxt;
  logic [CUR_FW-1:0]  out_cur_r, out_cur_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic [ATTR_W-1:0]  out_attr_r, out_attr_nxt;
  logic               out_scr_r, out_scr_nxt;

  logic               out_free;
  logic               sweeping;
  logic               sw_copy;
  logic [CELL_W-1:0]  fill_cell;
  logic [CUR_W-1:0]   adv_cur, adv_base;
  logic [COL_W-1:0]   adv_col;
  logic               rd_in_range;

  assign out_free    = !out_v_r || out_tready;
  assign sweeping    = (state_r == S_INIT) || (state_r == S_SWEEP);
  assign sw_copy     = copy_r && (sw_r < LAST_ROW);
  assign fill_cell   = (state_r == S_INIT) ? CELL_W'(0) : {dattr_r, NUL_CHAR};
  assign rd_in_range = 32'(cmd_idx_r) < 32'(CELLS);

  // cursor after printing one cell
  always_comb begin
    adv_cur = cur_r + CUR_W'(1);
    if (col_r == COL_LAST) begin
      adv_col  = '0;
      adv_base = base_r + COLS_C;
    end else begin
      adv_col  = col_r + COL_W'(1);
      adv_base = base_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_op_nxt    = cmd_op_r;
    cmd_char_nxt  = cmd_char_r;
    cmd_attr_nxt  = cmd_attr_r;
    cmd_idx_nxt   = cmd_idx_r;
    cur_nxt       = cur_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    dattr_nxt     = cfg_we ? cfg_wdata : dattr_r;
    sw_nxt        = sw_r;
    copy_nxt      = copy_r;
    scr_nxt       = scr_r;
    put_after_nxt = put_after_r;
    pend_v_nxt    = 1'b0;
    pend_copy_nxt = pend_copy_r;
    pend_addr_nxt = pend_addr_r;
    out_v_nxt     = out_tready ? 1'b0 : out_v_r;
    out_cur_nxt   = out_cur_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_scr_nxt   = out_scr_r;
    in_tready     = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;

    // write side of the sweep: data read last cycle, or the fill value
    if (pend_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_r;
      mem_wdata = pend_copy_r ? mem_q_r : fill_cell;
    end

    // read side of the sweep: fetch the cell one row below
    if (sweeping && sw_r != CELLS_C) begin
      if (sw_copy) begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(sw_r + COLS_C);
      end
      pend_v_nxt    = 1'b1;
      pend_copy_nxt = sw_copy;
      pend_addr_nxt = ADDR_W'(sw_r);
      sw_nxt        = sw_r + CUR_W'(1);
    end

    case (state_r)
      S_INIT: begin
        if (sw_r == CELLS_C && !pend_v_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_op_nxt   = in_tuser;
          cmd_char_nxt = in_tdata[IN_CHAR_LSB +: CHAR_W];
          cmd_attr_nxt = in_tdata[IN_ATTR_LSB +: ATTR_W];
          cmd_idx_nxt  = in_tdata[IN_IDX_LSB +: IDX_W];
          state_nxt    = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          case (cmd_op_r)
            OP_PUT: begin
              if (cmd_char_r == NEWLINE_CHAR && base_r >= LAST_ROW) begin
                // newline on the last row: scroll, cursor to last row start
                cur_nxt       = LAST_ROW;
                base_nxt      = LAST_ROW;
                col_nxt       = '0;
                sw_nxt        = '0;
                copy_nxt      = 1'b1;
                scr_nxt       = 1'b1;
                put_after_nxt = 1'b0;
                state_nxt     = S_SWEEP;
              end else if (cmd_char_r == NEWLINE_CHAR) begin
                cur_nxt      = base_r + COLS_C;
                base_nxt     = base_r + COLS_C;
                col_nxt      = '0;
                out_v_nxt    = 1'b1;
                out_cur_nxt  = CUR_FW'(base_r + COLS_C);
                out_char_nxt = '0;
                out_attr_nxt = '0;
                out_scr_nxt  = 1'b0;
                state_nxt    = S_IDLE;
              end else if (cur_r == CELLS_C) begin
                // cursor past the end: scroll first, print afterwards
                cur_nxt       = LAST_ROW;
                base_nxt      = LAST_ROW;
                col_nxt       = '0;
                sw_nxt        = '0;
                copy_nxt      = 1'b1;
                scr_nxt       = 1'b1;
                put_after_nxt = 1'b1;
                state_nxt     = S_SWEEP;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = ADDR_W'(cur_r);
                mem_wdata    = {cmd_attr_r, cmd_char_r};
                cur_nxt      = adv_cur;
                base_nxt     = adv_base;
                col_nxt      = adv_col;
                out_v_nxt    = 1'b1;
                out_cur_nxt  = CUR_FW'(adv_cur);
                out_char_nxt = '0;
                out_attr_nxt = '0;
                out_scr_nxt  = 1'b0;
                state_nxt    = S_IDLE;
              end
            end
            OP_READ: begin
              if (rd_in_range) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(cmd_idx_r);
                state_nxt = S_RDATA;
              end else begin
                out_v_nxt    = 1'b1;
                out_cur_nxt  = CUR_FW'(cur_r);
                out_char_nxt = '0;
                out_attr_nxt = '0;
                out_scr_nxt  = 1'b0;
                state_nxt    = S_IDLE;
              end
            end
            OP_CLEAR: begin
              cur_nxt       = '0;
              base_nxt      = '0;
              col_nxt       = '0;
              sw_nxt        = '0;
              copy_nxt      = 1'b0;
              scr_nxt       = 1'b0;
              put_after_nxt = 1'b0;
              state_nxt     = S_SWEEP;
            end
            default: begin
              out_v_nxt    = 1'b1;
              out_cur_nxt  = CUR_FW'(cur_r);
              out_char_nxt = '0;
              out_attr_nxt = '0;
              out_scr_nxt  = 1'b0;
              state_nxt    = S_IDLE;
            end
          endcase
        end
      end

      S_RDATA: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_cur_nxt  = CUR_FW'(cur_r);
          out_char_nxt = mem_q_r[CHAR_W-1:0];
          out_attr_nxt = mem_q_r[CELL_W-1:CHAR_W];
          out_scr_nxt  = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      S_SWEEP: begin
        // last write drained: print the held character if any, report
        if (sw_r == CELLS_C && !pend_v_r && out_free) begin
          out_v_nxt    = 1'b1;
          out_char_nxt = '0;
          out_attr_nxt = '0;
          out_scr_nxt  = scr_r;
          state_nxt    = S_IDLE;
          if (put_after_r) begin
            mem_we      = 1'b1;
            mem_waddr   = ADDR_W'(cur_r);
            mem_wdata   = {cmd_attr_r, cmd_char_r};
            cur_nxt     = adv_cur;
            base_nxt    = adv_base;
            col_nxt     = adv_col;
            out_cur_nxt = CUR_FW'(adv_cur);
          end else begin
            out_cur_nxt = CUR_FW'(cur_r);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_r       <= '0;
      base_r      <= '0;
      col_r       <= '0;
      dattr_r     <= DEF_ATTR_RST;
      sw_r        <= '0;
      copy_r      <= 1'b0;
      scr_r       <= 1'b0;
      put_after_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      base_r      <= base_nxt;
      col_r       <= col_nxt;
      dattr_r     <= dattr_nxt;
      sw_r        <= sw_nxt;
      copy_r      <= copy_nxt;
      scr_r       <= scr_nxt;
      put_after_r <= put_after_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    cmd_op_r    <= cmd_op_nxt;
    cmd_char_r  <= cmd_char_nxt;
    cmd_attr_r  <= cmd_attr_nxt;
    cmd_idx_r   <= cmd_idx_nxt;
    pend_copy_r <= pend_copy_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_cur_r   <= out_cur_nxt;
    out_char_r  <= out_char_nxt;
    out_attr_r  <= out_attr_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  // cell RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= cell_mem_r[mem_raddr];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_scr_r, out_attr_r,
                       out_char_r, out_cur_r};

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checks on the text console writer, bound to the top level.
`include "assert_macros.svh"

module tcw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready
);
  import tcw_pkg::*;

  logic [CUR_FW-1:0] out_cur;
  logic              out_scr;
  logic              scr_cur_ok;

  assign out_cur    = out_tdata[OUT_CUR_LSB +: CUR_FW];
  assign out_scr    = out_tdata[OUT_SCR_BIT];
  assign scr_cur_ok = (32'(out_cur) == 32'(CELLS - COLUMNS)) ||
                      (32'(out_cur) == 32'(CELLS - COLUMNS + 1));

  // stalled result word holds
  `TCW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // cursor never beyond one past the last cell
  `TCW_ASSERT_IMP(a_cur_range, out_tvalid, 32'(out_cur) <= 32'(CELLS))

  // a scroll leaves the cursor at the last row start, or one cell after it
  `TCW_ASSERT_IMP(a_scroll_cur, out_tvalid && out_scr, scr_cur_ok)

  // one word in flight: the cycle after an accept is always busy
  `TCW_ASSERT_NXT(a_one_word, in_tvalid && in_tready, !in_tready)

  // reset empties the result register and holds off input
  `TCW_ASSERT_NXT_NR(a_reset_quiet, !rst_n, !out_tvalid && !in_tready)

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
